### rtl/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg
// Types and constants shared by the HSV to RGB converter: payload structs,
// fixed-point formats, hue geometry and the sector codes.
// ----------------------------------------------------------------------------
package h2r_pkg;

    localparam int FRAC_BITS = 12;
    localparam int CHAN_W    = FRAC_BITS + 1;
    localparam int HUE_W     = 15;
    localparam int REM_W     = 12;
    localparam int PROD_W    = 2 * CHAN_W;

    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [FRAC_BITS-1:0] frac_t;
    typedef logic [HUE_W-1:0]     hue_t;
    typedef logic [REM_W-1:0]     rem_t;
    typedef logic [PROD_W-1:0]    prod_t;

    localparam chan_t UNIT_ONE   = chan_t'(1 << FRAC_BITS);
    localparam hue_t  HUE_TURN   = 15'd23040;
    localparam hue_t  HUE_SECTOR = 15'd3840;

    // f = rem * 4096 / 3840 = rem + rem / 15, rem / 15 by reciprocal
    localparam int    RECIP_W     = 25;
    localparam int    RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_15 = 25'd4370;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    typedef struct packed {
        hue_t  hue;
        chan_t saturation;
        chan_t brightness;
    } hsv_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    // the four candidate levels that the sector routes to the channels
    typedef struct packed {
        chan_t v;
        chan_t p;
        chan_t q;
        chan_t t;
    } levels_t;

endpackage

### rtl/h2r_route.sv
// ----------------------------------------------------------------------------
// h2r_route
// Routes v, p, q and t onto red, green and blue by hue sector; grey pixels
// take the value level on all three channels.
// ----------------------------------------------------------------------------
module h2r_route (
    input  h2r_pkg::sector_t sector,
    input  logic             grey,
    input  h2r_pkg::levels_t lvl,
    output h2r_pkg::rgb_t    rgb
);
    import h2r_pkg::*;

    always_comb begin
        if (grey) begin
            rgb = '{red: lvl.v, green: lvl.v, blue: lvl.v};
        end else begin
            case (sector)
                SEC_RED:    rgb = '{red: lvl.v, green: lvl.t, blue: lvl.p};
                SEC_YELLOW: rgb = '{red: lvl.q, green: lvl.v, blue: lvl.p};
                SEC_GREEN:  rgb = '{red: lvl.p, green: lvl.v, blue: lvl.t};
                SEC_CYAN:   rgb = '{red: lvl.p, green: lvl.q, blue: lvl.v};
                SEC_BLUE:   rgb = '{red: lvl.t, green: lvl.p, blue: lvl.v};
                default:    rgb = '{red: lvl.v, green: lvl.p, blue: lvl.q};
            endcase
        end
    end

endmodule

### rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Six-sector hexcone HSV to RGB conversion of a pixel stream, Q1.12 channels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled and gives one result per pixel, in
// order, passing through six stages from request to result valid. They are:
// hue wrap and clamps, sector search, fraction and p, the two s*f products,
// the two v*(1-..) products, and routing into the output register. The depth
// is set by the chain of two dependent multiplies behind q and t, each given
// a stage of its own. Every stage has its own valid bit and moves whenever
// the stage after it is empty or moving, so bubbles close up under
// back-pressure and s_ready stays high while any stage is free. Saturation
// and brightness above 1.0 are clamped, and a hue of 360 degrees or more
// wraps by one turn. The fixed-point width is fixed at 12 fraction bits.
module hsv_to_rgb_converter (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  h2r_pkg::hsv_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output h2r_pkg::rgb_t m_data
);
    import h2r_pkg::*;

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   rdy;

    // stage 0: wrap and clamps
    hue_t    h0_reg,  h0_next;
    chan_t   s0_reg,  s0_next;
    chan_t   v0_reg,  v0_next;
    logic    g0_reg,  g0_next;
    // stage 1: sector search
    sector_t sec1_reg, sec1_next;
    rem_t    rem1_reg, rem1_next;
    chan_t   s1_reg, v1_reg;
    logic    g1_reg;
    // stage 2: fraction and p
    frac_t   f2_reg,  f2_next;
    chan_t   p2_reg,  p2_next;
    chan_t   s2_reg, v2_reg;
    sector_t sec2_reg;
    logic    g2_reg;
    // stage 3: s*f and s*(1-f)
    chan_t   a3_reg,  a3_next;
    chan_t   b3_reg,  b3_next;
    chan_t   p3_reg, v3_reg;
    sector_t sec3_reg;
    logic    g3_reg;
    // stage 4: q and t
    chan_t   q4_reg,  q4_next;
    chan_t   t4_reg,  t4_next;
    chan_t   p4_reg, v4_reg;
    sector_t sec4_reg;
    logic    g4_reg;
    // stage 5: output
    rgb_t    out_reg, out_next;

    logic [RECIP_W-1:0] frac_prod;
    prod_t p_prod, sf_prod, s1f_prod, q_prod, t_prod;
    chan_t one_minus_f;
    levels_t lvl;

    // ready chain from the output side back to the input
    always_comb begin
        rdy[STAGES] = m_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[STAGES-1];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 0
    always_comb begin
        h0_next = (s_data.hue >= HUE_TURN) ? s_data.hue - HUE_TURN : s_data.hue;
        s0_next = (s_data.saturation > UNIT_ONE) ? UNIT_ONE : s_data.saturation;
        v0_next = (s_data.brightness > UNIT_ONE) ? UNIT_ONE : s_data.brightness;
        g0_next = (s_data.saturation == '0);
    end

    // stage 1
    always_comb begin
        hue_t base;
        if (h0_reg >= hue_t'(5 * HUE_SECTOR)) begin
            sec1_next = SEC_MAGENTA;
            base      = hue_t'(5 * HUE_SECTOR);
        end else if (h0_reg >= hue_t'(4 * HUE_SECTOR)) begin
            sec1_next = SEC_BLUE;
            base      = hue_t'(4 * HUE_SECTOR);
        end else if (h0_reg >= hue_t'(3 * HUE_SECTOR)) begin
            sec1_next = SEC_CYAN;
            base      = hue_t'(3 * HUE_SECTOR);
        end else if (h0_reg >= hue_t'(2 * HUE_SECTOR)) begin
            sec1_next = SEC_GREEN;
            base      = hue_t'(2 * HUE_SECTOR);
        end else if (h0_reg >= HUE_SECTOR) begin
            sec1_next = SEC_YELLOW;
            base      = HUE_SECTOR;
        end else begin
            sec1_next = SEC_RED;
            base      = '0;
        end
        rem1_next = rem_t'(h0_reg - base);
    end

    // stage 2
    always_comb begin
        frac_prod = RECIP_W'(rem1_reg) * RECIP_15;
        f2_next   = frac_t'(rem1_reg) + frac_t'(frac_prod[RECIP_W-1:RECIP_SHIFT]);
        p_prod    = PROD_W'(v1_reg) * PROD_W'(UNIT_ONE - s1_reg);
        p2_next   = p_prod[FRAC_BITS +: CHAN_W];
    end

    // stage 3
    always_comb begin
        one_minus_f = UNIT_ONE - CHAN_W'(f2_reg);
        sf_prod     = PROD_W'(s2_reg) * PROD_W'(f2_reg);
        s1f_prod    = PROD_W'(s2_reg) * PROD_W'(one_minus_f);
        a3_next     = UNIT_ONE - sf_prod[FRAC_BITS +: CHAN_W];
        b3_next     = UNIT_ONE - s1f_prod[FRAC_BITS +: CHAN_W];
    end

    // stage 4
    always_comb begin
        q_prod  = PROD_W'(v3_reg) * PROD_W'(a3_reg);
        t_prod  = PROD_W'(v3_reg) * PROD_W'(b3_reg);
        q4_next = q_prod[FRAC_BITS +: CHAN_W];
        t4_next = t_prod[FRAC_BITS +: CHAN_W];
    end

    // stage 5
    assign lvl = '{v: v4_reg, p: p4_reg, q: q4_reg, t: t4_reg};

    h2r_route u_route (
        .sector (sec4_reg),
        .grey   (g4_reg),
        .lvl    (lvl),
        .rgb    (out_next)
    );

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            h0_reg <= h0_next;
            s0_reg <= s0_next;
            v0_reg <= v0_next;
            g0_reg <= g0_next;
        end
        if (rdy[1]) begin
            sec1_reg <= sec1_next;
            rem1_reg <= rem1_next;
            s1_reg   <= s0_reg;
            v1_reg   <= v0_reg;
            g1_reg   <= g0_reg;
        end
        if (rdy[2]) begin
            f2_reg   <= f2_next;
            p2_reg   <= p2_next;
            s2_reg   <= s1_reg;
            v2_reg   <= v1_reg;
            sec2_reg <= sec1_reg;
            g2_reg   <= g1_reg;
        end
        if (rdy[3]) begin
            a3_reg   <= a3_next;
            b3_reg   <= b3_next;
            p3_reg   <= p2_reg;
            v3_reg   <= v2_reg;
            sec3_reg <= sec2_reg;
            g3_reg   <= g2_reg;
        end
        if (rdy[4]) begin
            q4_reg   <= q4_next;
            t4_reg   <= t4_next;
            p4_reg   <= p3_reg;
            v4_reg   <= v3_reg;
            sec4_reg <= sec3_reg;
            g4_reg   <= g3_reg;
        end
        if (rdy[5]) begin
            out_reg <= out_next;
        end
    end

endmodule

### sim/hsv_to_rgb_converter_tb.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Self-checking bench for the HSV to RGB converter. A short table of directed
// pixels covers black, grey, the primaries, every sector, the hue wrap and
// the clamps. Random pixels follow under four idle/stall phases on the two
// channels. Every result is checked per channel against the table's own
// expected value where it gives one, else an in-bench hexcone predictor.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import h2r_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_PHASE  = 250;
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int IDLE_PCT_HIGH = 77;
    localparam int IDLE_PCT_LOW  = 24;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        hsv_t pixel;
        bit   known;
        rgb_t want;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    hsv_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rgb_t m_data;

    idle_mode_t idle_mode = IDLE_NONE;
    dir_row_t   directed_rows[$];
    rgb_t       expected_rgb[$];
    rgb_t       head_rgb;
    int         mismatches    = 0;
    int         results_seen  = 0;
    int         pixels_sent   = 0;
    int         quiet_cycles  = 0;

    hsv_to_rgb_converter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint unsigned mul_trunc(input longint unsigned a,
                                                  input longint unsigned b);
        return (a * b) >> FRAC_BITS;
    endfunction

    // six-sector hexcone conversion, products truncated
    function automatic rgb_t hexcone_rgb(input hsv_t px);
        longint unsigned one, h, s, v, rem, f, p, q, t;
        sector_t         sec;
        rgb_t            res;
        one = longint'(UNIT_ONE);
        h   = longint'(px.hue) % longint'(HUE_TURN);
        s   = (px.saturation > UNIT_ONE) ? one : longint'(px.saturation);
        v   = (px.brightness > UNIT_ONE) ? one : longint'(px.brightness);
        if (s == 0) begin
            res = '{red: chan_t'(v), green: chan_t'(v), blue: chan_t'(v)};
        end else begin
            sec = sector_t'(h / longint'(HUE_SECTOR));
            rem = h % longint'(HUE_SECTOR);
            f   = (rem << FRAC_BITS) / longint'(HUE_SECTOR);
            p   = mul_trunc(v, one - s);
            q   = mul_trunc(v, one - mul_trunc(s, f));
            t   = mul_trunc(v, one - mul_trunc(s, one - f));
            case (sec)
                SEC_RED:    res = '{red: chan_t'(v), green: chan_t'(t), blue: chan_t'(p)};
                SEC_YELLOW: res = '{red: chan_t'(q), green: chan_t'(v), blue: chan_t'(p)};
                SEC_GREEN:  res = '{red: chan_t'(p), green: chan_t'(v), blue: chan_t'(t)};
                SEC_CYAN:   res = '{red: chan_t'(p), green: chan_t'(q), blue: chan_t'(v)};
                SEC_BLUE:   res = '{red: chan_t'(t), green: chan_t'(p), blue: chan_t'(v)};
                default:    res = '{red: chan_t'(v), green: chan_t'(p), blue: chan_t'(q)};
            endcase
        end
        return res;
    endfunction

    function automatic chan_t rand_level();
        case ($urandom_range(9))
            0:       return chan_t'(0);
            1:       return chan_t'($urandom_range(8191));
            2:       return UNIT_ONE;
            default: return chan_t'($urandom_range(4096));
        endcase
    endfunction

    function automatic hsv_t rand_pixel();
        hsv_t px;
        int   h;
        case ($urandom_range(9))
            0: h = $urandom_range(32767);
            1: h = $urandom_range(32767, 23040);
            2: begin
                // straddle a sector boundary
                h = $urandom_range(6) * 3840 + $urandom_range(4) - 2;
                if (h < 0) h = h + 23040;
            end
            default: h = $urandom_range(23039);
        endcase
        px.hue        = hue_t'(h);
        px.saturation = rand_level();
        px.brightness = rand_level();
        return px;
    endfunction

    function automatic bit idle_now(input bit sender_side);
        case (idle_mode)
            IDLE_SENDER:   return sender_side && ($urandom_range(99) < IDLE_PCT_HIGH);
            IDLE_RECEIVER: return !sender_side && ($urandom_range(99) < IDLE_PCT_HIGH);
            IDLE_BOTH:     return $urandom_range(99) < IDLE_PCT_LOW;
            default:       return 1'b0;
        endcase
    endfunction

    task automatic add_row(input int h, input int s, input int v, input bit known,
                           input int r, input int g, input int b);
        dir_row_t row;
        row.pixel = '{hue: hue_t'(h), saturation: chan_t'(s), brightness: chan_t'(v)};
        row.known = known;
        row.want  = '{red: chan_t'(r), green: chan_t'(g), blue: chan_t'(b)};
        directed_rows.push_back(row);
    endtask

    task automatic send_pixel(input hsv_t px, input rgb_t want);
        while (idle_now(1'b1)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        expected_rgb.push_back(want);
        pixels_sent++;
    endtask

    task automatic check_chan(input string name, input chan_t want, input chan_t got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_now(1'b0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_rgb.size() == 0) begin
                $error("result with no request outstanding: %h", m_data);
                mismatches++;
            end else begin
                head_rgb = expected_rgb.pop_front();
                check_chan("red",   head_rgb.red,   m_data.red);
                check_chan("green", head_rgb.green, m_data.green);
                check_chan("blue",  head_rgb.blue,  m_data.blue);
                results_seen++;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        hsv_t px;
        int   directed_count;

        add_row(0,     0,    0,    1, 0,    0,    0);
        add_row(0,     0,    4096, 1, 4096, 4096, 4096);
        add_row(5000,  0,    2048, 1, 2048, 2048, 2048);
        add_row(0,     0,    8191, 1, 4096, 4096, 4096);
        add_row(0,     4096, 4096, 1, 4096, 0,    0);
        add_row(23040, 4096, 4096, 1, 4096, 0,    0);
        add_row(7680,  4096, 4096, 1, 0,    4096, 0);
        add_row(11520, 4096, 4096, 1, 0,    4096, 4096);
        add_row(15360, 4096, 4096, 1, 0,    0,    4096);
        add_row(0,     8191, 4096, 1, 4096, 0,    0);
        add_row(0,     4096, 8191, 1, 4096, 0,    0);
        add_row(0,     8191, 8191, 1, 4096, 0,    0);
        add_row(32767, 4096, 4096, 0, 0, 0, 0);
        add_row(1920,  4096, 4096, 0, 0, 0, 0);
        add_row(5760,  3000, 4096, 0, 0, 0, 0);
        add_row(9600,  2048, 3000, 0, 0, 0, 0);
        add_row(13440, 4096, 1234, 0, 0, 0, 0);
        add_row(17280, 1000, 4096, 0, 0, 0, 0);
        add_row(21120, 4095, 4095, 0, 0, 0, 0);
        add_row(3839,  4096, 4096, 0, 0, 0, 0);
        add_row(3840,  2048, 4096, 0, 0, 0, 0);
        add_row(23039, 1,    4096, 0, 0, 0, 0);
        add_row(26880, 8191, 4096, 0, 0, 0, 0);
        add_row(19200, 4096, 1,    0, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            px = directed_rows[i].pixel;
            send_pixel(px, directed_rows[i].known ? directed_rows[i].want : hexcone_rgb(px));
        end
        directed_count = pixels_sent;

        for (int ph = IDLE_NONE; ph <= IDLE_BOTH; ph++) begin
            idle_mode = idle_mode_t'(ph);
            repeat (RANDOM_PHASE) begin
                px = rand_pixel();
                send_pixel(px, hexcone_rgb(px));
            end
        end
        s_valid <= 1'b0;

        while (expected_rgb.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("converted %0d directed and %0d random pixels, %0d results checked",
                 directed_count, pixels_sent - directed_count, results_seen);
        $display("phases: free-running, sender idle, receiver stall, both idling");
        if (mismatches == 0 && expected_rgb.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### hsv_to_rgb_converter.f
rtl/h2r_pkg.sv
rtl/h2r_route.sv
rtl/hsv_to_rgb_converter.sv
sim/hsv_to_rgb_converter_tb.sv
